>>> rtl/core/dbd_pkg.sv
// dbd_pkg: constants, register codes and shared types of the detection box decoder
// used by detection_box_decode, dbd_accum, dbd_scale and the bench; depends on nothing
`timescale 1ns / 1ps

package dbd_pkg;

    // class score count limit and coordinate fraction bits
    localparam int MAX_CLASSES     = 128;
    localparam int COORD_FRAC_BITS = 4;

    // element positions within one box
    localparam int POS_W      = 8;
    localparam int LAST_W     = 9;
    localparam int POS_CX     = 0;
    localparam int POS_CY     = 1;
    localparam int POS_W_SIZE = 2;
    localparam int POS_H_SIZE = 3;
    localparam int POS_OBJ    = 4;
    localparam int POS_CLASS0 = 5;

    // product shifts: edge uses 2*c - s, so one more bit than the extent
    localparam int EDGE_SHIFT = COORD_FRAC_BITS + 13;
    localparam int EXT_SHIFT  = COORD_FRAC_BITS + 12;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CONF_THRESHOLD = 3'd0,
        REG_NUM_CLASSES    = 3'd1,
        REG_INV_SCALE_X    = 3'd2,
        REG_INV_SCALE_Y    = 3'd3,
        REG_IMAGE_WIDTH    = 3'd4,
        REG_IMAGE_HEIGHT   = 3'd5
    } dbd_reg_t;

    // configuration register set
    typedef struct packed {
        logic [15:0] conf_threshold;
        logic [7:0]  num_classes;
        logic [15:0] inv_scale_x;
        logic [15:0] inv_scale_y;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } dbd_cfg_t;

    // one finished box, as gathered from its elements
    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [15:0] objectness;
        logic [15:0] best_score;
        logic [6:0]  best_class;
        logic [15:0] box_index;
    } dbd_box_t;

endpackage

>>> rtl/core/dbd_elem_if.sv
// dbd_elem_if: valid/ready channel carrying one detector output element per item
// depends on nothing
`timescale 1ns / 1ps

interface dbd_elem_if;
    logic        valid;
    logic        ready;
    logic [15:0] element_value;
    logic        first_of_frame;

    modport source (output valid, output element_value, output first_of_frame, input ready);
    modport sink (input valid, input element_value, input first_of_frame, output ready);
endinterface

>>> rtl/core/dbd_box_if.sv
// dbd_box_if: valid/ready channel carrying one decoded box per item
// depends on nothing
`timescale 1ns / 1ps

interface dbd_box_if;
    logic               valid;
    logic               ready;
    logic [15:0]        box_x;
    logic [15:0]        box_y;
    logic signed [16:0] box_width;
    logic signed [16:0] box_height;
    logic [6:0]         class_index;
    logic [15:0]        confidence;
    logic [15:0]        box_index;

    modport source (output valid, output box_x, output box_y, output box_width,
                    output box_height, output class_index, output confidence,
                    output box_index, input ready);
    modport sink (input valid, input box_x, input box_y, input box_width,
                  input box_height, input class_index, input confidence,
                  input box_index, output ready);
endinterface

>>> rtl/core/detection_box_decode.sv
// detection_box_decode: top level of the streaming detector box decoder
// depends on dbd_pkg, dbd_elem_if, dbd_box_if, dbd_accum and dbd_scale
`timescale 1ns / 1ps

//  channel   direction  item                        handshake
//  elem      in         one output element          valid/ready
//  boxes     out        one decoded corner box      valid/ready
//  cfg       in         register write              cfg_write, no wait
//
//  one element is taken every cycle until every stage is full; elements that do not
//  close a box give no result; a closed box passes the box register, the product
//  register (five 16x16/17x16 multipliers) and the result register
//  reset clears positions, box count and pipeline valid bits; registers return
//  to their documented defaults
//  a stalled output holds its box; elements keep flowing until every stage is full

module detection_box_decode (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    dbd_elem_if.sink    elem,
    dbd_box_if.source   boxes
);
    import dbd_pkg::*;

    dbd_cfg_t cfg_reg;
    logic     box_valid, box_ready;
    dbd_box_t box;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_threshold <= 16'd16384;
            cfg_reg.num_classes    <= 8'd80;
            cfg_reg.inv_scale_x    <= 16'd4096;
            cfg_reg.inv_scale_y    <= 16'd4096;
            cfg_reg.image_width    <= 13'd640;
            cfg_reg.image_height   <= 13'd640;
        end
        else if (cfg_write)
        begin
            case (dbd_reg_t'(cfg_index))
                REG_CONF_THRESHOLD: cfg_reg.conf_threshold <= cfg_data;
                REG_NUM_CLASSES:    cfg_reg.num_classes    <= cfg_data[7:0];
                REG_INV_SCALE_X:    cfg_reg.inv_scale_x    <= cfg_data;
                REG_INV_SCALE_Y:    cfg_reg.inv_scale_y    <= cfg_data;
                REG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data[12:0];
                REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data[12:0];
                default:            ;
            endcase
        end
    end

    // element gathering and argmax
    dbd_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_classes (cfg_reg.num_classes),
        .elem        (elem),
        .box_valid   (box_valid),
        .box         (box),
        .box_ready   (box_ready)
    );

    // confidence, scaling and result register
    dbd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .box_valid (box_valid),
        .box       (box),
        .box_ready (box_ready),
        .boxes     (boxes)
    );
endmodule

>>> rtl/core/dbd_accum.sv
// dbd_accum: element position tracking, running argmax and finished-box register
// depends on dbd_pkg and dbd_elem_if
`timescale 1ns / 1ps

module dbd_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        num_classes,
    dbd_elem_if.sink          elem,
    output logic              box_valid,
    output dbd_pkg::dbd_box_t box,
    input  logic              box_ready
);
    import dbd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       count_reg, count_next;
    logic [15:0]       cx_reg, cy_reg, w_reg, h_reg, obj_reg, best_reg;
    logic [6:0]        class_reg;
    logic              s1_valid_reg, s1_valid_next;
    dbd_box_t          s1_box_reg;

    logic [LAST_W-1:0] nc_eff, last_pos;
    logic [POS_W-1:0]  pos_cur, class_off;
    logic [15:0]       count_cur, best_new;
    logic [6:0]        class_new;
    logic              accept, closing;

    // effective class count and last position of a box
    always_comb
    begin
        nc_eff = {1'b0, num_classes};
        if (nc_eff == '0)
            nc_eff = LAST_W'(1);
        else if (nc_eff > LAST_W'(MAX_CLASSES))
            nc_eff = LAST_W'(MAX_CLASSES);
        last_pos = LAST_W'(POS_OBJ) + nc_eff;
    end

    // input handshake: the finished-box register frees up when taken
    assign elem.ready = !s1_valid_reg || box_ready;
    assign accept     = elem.valid && elem.ready;

    // frame start restarts position and count
    assign pos_cur   = elem.first_of_frame ? '0 : pos_reg;
    assign count_cur = elem.first_of_frame ? '0 : count_reg;
    assign closing   = {1'b0, pos_cur} >= last_pos;
    assign class_off = pos_cur - POS_W'(POS_CLASS0);

    // running argmax, first class wins on a tie
    always_comb
    begin
        best_new  = best_reg;
        class_new = class_reg;
        if (pos_cur == POS_W'(POS_CLASS0) || elem.element_value > best_reg)
        begin
            best_new  = elem.element_value;
            class_new = class_off[6:0];
        end
    end

    // position and count update
    always_comb
    begin
        pos_next      = pos_reg;
        count_next    = count_reg;
        s1_valid_next = s1_valid_reg && !box_ready;
        if (accept)
        begin
            if (closing)
            begin
                pos_next      = '0;
                count_next    = count_cur + 16'd1;
                s1_valid_next = 1'b1;
            end
            else
            begin
                pos_next   = pos_cur + POS_W'(1);
                count_next = count_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // element capture by position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            case (pos_cur)
                POS_W'(POS_CX):     cx_reg  <= elem.element_value;
                POS_W'(POS_CY):     cy_reg  <= elem.element_value;
                POS_W'(POS_W_SIZE): w_reg   <= elem.element_value;
                POS_W'(POS_H_SIZE): h_reg   <= elem.element_value;
                POS_W'(POS_OBJ):    obj_reg <= elem.element_value;
                default:
                begin
                    best_reg  <= best_new;
                    class_reg <= class_new;
                end
            endcase
            if (closing)
            begin
                s1_box_reg.center_x   <= cx_reg;
                s1_box_reg.center_y   <= cy_reg;
                s1_box_reg.box_w      <= w_reg;
                s1_box_reg.box_h      <= h_reg;
                s1_box_reg.objectness <= obj_reg;
                s1_box_reg.best_score <= best_new;
                s1_box_reg.best_class <= class_new;
                s1_box_reg.box_index  <= count_cur;
            end
        end
    end

    assign box_valid = s1_valid_reg;
    assign box       = s1_box_reg;

    // position never runs past the last position of the largest box
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(POS_OBJ + MAX_CLASSES))
        else $error("element position past box end");

    // an accepted closing element always produces a finished box and restarts the position
    a_box_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        accept && closing |=> s1_valid_reg && pos_reg == '0)
        else $error("closing element did not produce a box");

    // a stalled finished box is not overwritten
    a_box_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !box_ready |=> s1_valid_reg && $stable(s1_box_reg))
        else $error("waiting box changed");
endmodule

>>> rtl/core/dbd_scale.sv
// dbd_scale: confidence and scaling products, thresholding, edge clamping, result register
// depends on dbd_pkg and dbd_box_if
`timescale 1ns / 1ps

module dbd_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  dbd_pkg::dbd_cfg_t cfg,
    input  logic              box_valid,
    input  dbd_pkg::dbd_box_t box,
    output logic              box_ready,
    dbd_box_if.source         boxes
);
    import dbd_pkg::*;

    localparam int XW = 34;

    logic               s2_valid_reg, out_valid_reg;
    logic [31:0]        conf_prod_reg, wx_prod_reg, hy_prod_reg;
    logic [32:0]        ex_prod_reg, ey_prod_reg;
    logic               x_pos_reg, y_pos_reg, obj_ok_reg;
    logic [6:0]         class_reg;
    logic [15:0]        index_reg;

    logic signed [17:0] twice_x, twice_y;
    logic               out_take, s2_take;
    logic [15:0]        conf_val, edge_x, edge_y;
    logic [32:0]        edge_x_full, edge_y_full;
    logic [31:0]        ext_x_full, ext_y_full;
    logic signed [XW-1:0] ext_x, ext_y, room_x, room_y, lim_x, lim_y;
    logic               keep;

    logic [15:0]        box_x_reg, box_y_reg, conf_out_reg, index_out_reg;
    logic signed [16:0] width_reg, height_reg;
    logic [6:0]         class_out_reg;

    // pipeline flow control
    assign out_take  = !out_valid_reg || boxes.ready;
    assign s2_take   = !s2_valid_reg || out_take;
    assign box_ready = s2_take;

    // doubled left and top edges in coordinate units
    assign twice_x = $signed({1'b0, box.center_x, 1'b0}) - $signed({2'b00, box.box_w});
    assign twice_y = $signed({1'b0, box.center_y, 1'b0}) - $signed({2'b00, box.box_h});

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_take)
            s2_valid_reg <= box_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && box_valid)
        begin
            conf_prod_reg <= 32'(box.objectness) * 32'(box.best_score);
            ex_prod_reg   <= 33'(twice_x[16:0]) * 33'(cfg.inv_scale_x);
            ey_prod_reg   <= 33'(twice_y[16:0]) * 33'(cfg.inv_scale_y);
            wx_prod_reg   <= 32'(box.box_w) * 32'(cfg.inv_scale_x);
            hy_prod_reg   <= 32'(box.box_h) * 32'(cfg.inv_scale_y);
            x_pos_reg     <= !twice_x[17] && (twice_x != '0);
            y_pos_reg     <= !twice_y[17] && (twice_y != '0);
            obj_ok_reg    <= box.objectness >= cfg.conf_threshold;
            class_reg     <= box.best_class;
            index_reg     <= box.box_index;
        end
    end

    // confidence and keep decision
    assign conf_val = conf_prod_reg[31:16];
    assign keep     = obj_ok_reg && (conf_val >= cfg.conf_threshold);

    // edges: zero when not positive, saturate at the top
    always_comb
    begin
        edge_x_full = ex_prod_reg >> EDGE_SHIFT;
        edge_y_full = ey_prod_reg >> EDGE_SHIFT;
        edge_x = '0;
        edge_y = '0;
        if (x_pos_reg)
            edge_x = (edge_x_full > 33'hFFFF) ? 16'hFFFF : edge_x_full[15:0];
        if (y_pos_reg)
            edge_y = (edge_y_full > 33'hFFFF) ? 16'hFFFF : edge_y_full[15:0];
    end

    // extents limited to the distance to the image edge
    always_comb
    begin
        ext_x_full = wx_prod_reg >> EXT_SHIFT;
        ext_y_full = hy_prod_reg >> EXT_SHIFT;
        ext_x  = $signed({2'b00, ext_x_full});
        ext_y  = $signed({2'b00, ext_y_full});
        room_x = $signed(XW'(cfg.image_width)) - $signed(XW'(edge_x));
        room_y = $signed(XW'(cfg.image_height)) - $signed(XW'(edge_y));
        lim_x  = (ext_x < room_x) ? ext_x : room_x;
        lim_y  = (ext_y < room_y) ? ext_y : room_y;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_take)
            out_valid_reg <= s2_valid_reg && keep;
    end

    always_ff @(posedge clk)
    begin
        if (out_take && s2_valid_reg)
        begin
            box_x_reg     <= edge_x;
            box_y_reg     <= edge_y;
            width_reg     <= lim_x[16:0];
            height_reg    <= lim_y[16:0];
            class_out_reg <= class_reg;
            conf_out_reg  <= conf_val;
            index_out_reg <= index_reg;
        end
    end

    assign boxes.valid       = out_valid_reg;
    assign boxes.box_x       = box_x_reg;
    assign boxes.box_y       = box_y_reg;
    assign boxes.box_width   = width_reg;
    assign boxes.box_height  = height_reg;
    assign boxes.class_index = class_out_reg;
    assign boxes.confidence  = conf_out_reg;
    assign boxes.box_index   = index_out_reg;

    // an emitted box always passes the confidence threshold
    a_conf_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> conf_out_reg >= cfg.conf_threshold)
        else $error("box below confidence threshold emitted");

    // a new result comes only from a valid product stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result without product stage item");

    // the width never exceeds the room to the right image edge
    a_width_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $signed(XW'(width_reg)) + $signed(XW'(box_x_reg))
                          <= $signed(XW'(cfg.image_width)))
        else $error("box width past image edge");
endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for detection_box_decode; streams detector elements,
// predicts every decoded box in step and checks each box leaving the block
// depends on dbd_pkg, dbd_elem_if, dbd_box_if and the detection_box_decode rtl
`timescale 1ns / 1ps

module tb_top;
    import dbd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int QUEUE_CAP     = 64;
    localparam int MAX_REPORTS   = 10;

    // one element waiting to be sent
    typedef struct packed {
        logic [15:0] value;
        logic        first;
    } element_t;

    // one decoded box as it leaves the block
    typedef struct packed {
        logic [15:0]        box_x;
        logic [15:0]        box_y;
        logic signed [16:0] box_width;
        logic signed [16:0] box_height;
        logic [6:0]         class_index;
        logic [15:0]        confidence;
        logic [15:0]        box_index;
    } box_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    dbd_elem_if elem_ch ();
    dbd_box_if  box_ch ();

    detection_box_decode dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .elem      (elem_ch),
        .boxes     (box_ch)
    );

    // shadow registers and box being gathered
    dbd_cfg_t    cfg_q;
    logic [7:0]  pos_q;
    logic [15:0] frame_boxes;
    logic [15:0] cx_q;
    logic [15:0] cy_q;
    logic [15:0] w_q;
    logic [15:0] h_q;
    logic [15:0] obj_q;
    logic [15:0] best_q;
    logic [6:0]  cls_q;

    box_result_t boxes_due[$];
    element_t    elements_to_send[$];
    element_t    next_elem;
    box_result_t got_box;

    // traffic control
    int   items_pushed;
    int   cur_classes;
    int   cur_thr;
    int   gap_left;
    int   burst_left;
    int   hold_left;
    int   rx_mode;
    int   rx_left;
    int   rx_tick;
    int   idle_cycles;
    int   mismatches;
    logic steady_feed;
    logic hold_req;
    logic elem_fire;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // left or top edge in image pixels, from center and size
    function automatic longint left_edge(input logic [15:0] c, input logic [15:0] s,
                                         input logic [15:0] inv);
        longint twice;
        twice = 2 * longint'(c) - longint'(s);
        if (twice <= 0)
            return 0;
        twice = (twice * longint'(inv)) >>> EDGE_SHIFT;
        return (twice > 65535) ? 65535 : twice;
    endfunction

    // width or height, limited to the room left before the image edge
    function automatic longint extent(input logic [15:0] s, input logic [15:0] inv,
                                      input longint edge_px, input logic [12:0] limit);
        longint v;
        longint room;
        v = (longint'(s) * longint'(inv)) >>> EXT_SHIFT;
        room = longint'(limit) - edge_px;
        return (v < room) ? v : room;
    endfunction

    // advance the box decoder by one element, queue the box it emits if any
    function automatic void decode_element(input logic [15:0] v, input logic fof);
        int          classes;
        int          pos;
        logic [31:0] product;
        logic [15:0] conf;
        logic [15:0] idx;
        longint      left_px;
        longint      top_px;
        box_result_t r;
        classes = cfg_q.num_classes;
        if (classes == 0)
            classes = 1;
        if (classes > MAX_CLASSES)
            classes = MAX_CLASSES;
        if (fof)
        begin
            pos_q = '0;
            frame_boxes = '0;
        end
        pos = pos_q;
        case (pos)
            POS_CX:     cx_q = v;
            POS_CY:     cy_q = v;
            POS_W_SIZE: w_q = v;
            POS_H_SIZE: h_q = v;
            POS_OBJ:    obj_q = v;
            default:
            begin
                // running argmax, first index wins a tie
                if (pos == POS_CLASS0 || v > best_q)
                begin
                    best_q = v;
                    cls_q = 7'(pos - POS_CLASS0);
                end
            end
        endcase
        if (pos >= POS_OBJ + classes)
        begin
            product = obj_q * best_q;
            conf = product[31:16];
            idx = frame_boxes;
            pos_q = '0;
            frame_boxes = frame_boxes + 16'd1;
            if (obj_q >= cfg_q.conf_threshold && conf >= cfg_q.conf_threshold)
            begin
                left_px = left_edge(cx_q, w_q, cfg_q.inv_scale_x);
                top_px = left_edge(cy_q, h_q, cfg_q.inv_scale_y);
                r.box_x = 16'(left_px);
                r.box_y = 16'(top_px);
                r.box_width = 17'(extent(w_q, cfg_q.inv_scale_x, left_px, cfg_q.image_width));
                r.box_height = 17'(extent(h_q, cfg_q.inv_scale_y, top_px, cfg_q.image_height));
                r.class_index = cls_q;
                r.confidence = conf;
                r.box_index = idx;
                boxes_due = {boxes_due, r};
            end
        end
        else
        begin
            pos_q = 8'(pos + 1);
        end
    endfunction

    function automatic string show_box(input box_result_t b);
        return $sformatf("x=%0d y=%0d w=%0d h=%0d class=%0d conf=%0d index=%0d",
                         b.box_x, b.box_y, b.box_width, b.box_height,
                         b.class_index, b.confidence, b.box_index);
    endfunction

    // coordinates: full range, small, extremes and typical pixel values
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 16'h1FFF));
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(16'h0100, 16'h2800));
        endcase
    endfunction

    function automatic logic [15:0] rand_score();
        if ($urandom_range(0, 1))
            return 16'($urandom);
        return 16'($urandom_range(cur_thr, 65535));
    endfunction

    // element queue, kept short so the stimulus follows the block
    task automatic push_elem(input logic [15:0] v, input logic fof);
        element_t e;
        while (elements_to_send.size() >= QUEUE_CAP)
            @(posedge clk);
        e.value = v;
        e.first = fof;
        elements_to_send = {elements_to_send, e};
        items_pushed++;
    endtask

    task automatic push_head(input logic fof, input logic [15:0] cx, input logic [15:0] cy,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] obj);
        push_elem(cx, fof);
        push_elem(cy, 1'b0);
        push_elem(w, 1'b0);
        push_elem(h, 1'b0);
        push_elem(obj, 1'b0);
    endtask

    // well-formed box with random content, ties now and then
    task automatic random_box(input logic fof);
        logic [15:0] prev;
        logic [15:0] s;
        int          i;
        prev = '0;
        push_head(fof, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  $urandom_range(0, 1) ? 16'($urandom_range(cur_thr, 65535)) : 16'($urandom));
        for (i = 0; i < cur_classes; i++)
        begin
            s = (i > 0 && $urandom_range(0, 7) == 0) ? prev : rand_score();
            push_elem(s, 1'b0);
            prev = s;
        end
    endtask

    // mostly whole boxes, some cut short and restarted, some stray elements
    task automatic random_traffic(input int n_items);
        int start;
        int pick;
        int k;
        int i;
        start = items_pushed;
        while (items_pushed - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                random_box($urandom_range(0, 9) == 0);
            end
            else if (pick < 90)
            begin
                k = $urandom_range(1, 4 + cur_classes);
                for (i = 0; i < k; i++)
                    push_elem(16'($urandom), 1'b0);
                random_box(1'b1);
            end
            else
            begin
                push_elem(16'($urandom), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // wait until the block has taken everything and every box has left
    task automatic settle();
        while (elements_to_send.size() != 0 || elem_ch.valid)
            @(posedge clk);
        while (boxes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input dbd_reg_t r, input logic [15:0] d);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(input int thr, input int nc, input int isx, input int isy,
                             input int iw, input int ih);
        int nc8;
        write_reg(REG_CONF_THRESHOLD, 16'(thr));
        write_reg(REG_NUM_CLASSES, 16'(nc));
        write_reg(REG_INV_SCALE_X, 16'(isx));
        write_reg(REG_INV_SCALE_Y, 16'(isy));
        write_reg(REG_IMAGE_WIDTH, 16'(iw));
        write_reg(REG_IMAGE_HEIGHT, 16'(ih));
        nc8 = nc & 255;
        cur_classes = (nc8 == 0) ? 1 : ((nc8 > MAX_CLASSES) ? MAX_CLASSES : nc8);
        cur_thr = thr & 16'hFFFF;
    endtask

    task automatic run_phase(input int thr, input int nc, input int isx, input int isy,
                             input int iw, input int ih, input int n_items);
        settle();
        write_all(thr, nc, isx, isy, iw, ih);
        random_traffic(n_items);
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            elem_ch.valid <= 1'b0;
        end
        else if (!elem_ch.valid || elem_fire)
        begin
            if (steady_feed)
                gap_left = 0;
            if (gap_left > 0)
            begin
                gap_left--;
                elem_ch.valid <= 1'b0;
            end
            else if (elements_to_send.size() > 0)
            begin
                next_elem = elements_to_send.pop_front();
                elem_ch.valid <= 1'b1;
                elem_ch.element_value <= next_elem.value;
                elem_ch.first_of_frame <= next_elem.first;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                elem_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes mode now and then, long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            box_ch.ready <= 1'b0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                box_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(32, 200);
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    0:       box_ch.ready <= 1'b1;
                    1:       box_ch.ready <= 1'($urandom_range(0, 1));
                    default: box_ch.ready <= (rx_tick % 5) >= 2;
                endcase
            end
        end
    end

    // register writes, element prediction and box checking at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            elem_fire <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (dbd_reg_t'(cfg_index))
                    REG_CONF_THRESHOLD: cfg_q.conf_threshold = cfg_data;
                    REG_NUM_CLASSES:    cfg_q.num_classes = cfg_data[7:0];
                    REG_INV_SCALE_X:    cfg_q.inv_scale_x = cfg_data;
                    REG_INV_SCALE_Y:    cfg_q.inv_scale_y = cfg_data;
                    REG_IMAGE_WIDTH:    cfg_q.image_width = cfg_data[12:0];
                    REG_IMAGE_HEIGHT:   cfg_q.image_height = cfg_data[12:0];
                    default:            ;
                endcase
            end
            elem_fire <= elem_ch.valid && elem_ch.ready;
            if (elem_ch.valid && elem_ch.ready)
                decode_element(elem_ch.element_value, elem_ch.first_of_frame);
            if (box_ch.valid && box_ch.ready)
            begin
                got_box = '{box_ch.box_x, box_ch.box_y, box_ch.box_width, box_ch.box_height,
                            box_ch.class_index, box_ch.confidence, box_ch.box_index};
                if (boxes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected box: %s", show_box(got_box));
                end
                else
                begin
                    if (got_box !== boxes_due[0])
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("box mismatch at %0t", $realtime);
                            $display("  expected %s", show_box(boxes_due[0]));
                            $display("  actual   %s", show_box(got_box));
                        end
                    end
                    void'(boxes_due.pop_front());
                end
            end
        end
    end

    // watchdog on cycles in which nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elem_ch.valid && elem_ch.ready) || (box_ch.valid && box_ch.ready) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int          i;
        logic [15:0] s;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        elem_ch.valid = 1'b0;
        elem_ch.element_value = '0;
        elem_ch.first_of_frame = 1'b0;
        box_ch.ready = 1'b0;
        cfg_q = '{16'd16384, 8'd80, 16'd4096, 16'd4096, 13'd640, 13'd640};
        pos_q = '0;
        frame_boxes = '0;
        cx_q = '0;
        cy_q = '0;
        w_q = '0;
        h_q = '0;
        obj_q = '0;
        best_q = '0;
        cls_q = '0;
        items_pushed = 0;
        cur_classes = 80;
        cur_thr = 16384;
        gap_left = 0;
        burst_left = 0;
        hold_left = 0;
        rx_mode = 0;
        rx_left = 0;
        rx_tick = 0;
        idle_cycles = 0;
        mismatches = 0;
        steady_feed = 1'b0;
        hold_req = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // one box under the reset settings, tied best score at two classes
        push_head(1'b1, 16'h1400, 16'h0C80, 16'h0640, 16'h0320, 16'hFFFF);
        for (i = 0; i < 80; i++)
        begin
            s = (i == 40 || i == 60) ? 16'h9000 : 16'($urandom_range(0, 16'h8FFF));
            push_elem(s, 1'b0);
        end
        settle();
        write_all(16'h4000, 2, 16'h1000, 16'h2000, 640, 480);

        // far corner with zero size: width and height go negative
        push_head(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        push_elem(16'hFFFF, 1'b0);
        push_elem(16'hFFFF, 1'b0);
        // size beyond twice the center: edge clamps at zero, confidence just misses
        push_head(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h4000);
        push_elem(16'h0000, 1'b0);
        push_elem(16'hFFFF, 1'b0);
        // confidence exactly at the threshold
        push_head(1'b0, 16'h0A00, 16'h0A00, 16'h0500, 16'h0500, 16'h8000);
        push_elem(16'h8000, 1'b0);
        push_elem(16'h7FFF, 1'b0);
        // objectness just below the threshold
        push_head(1'b0, 16'h0800, 16'h0800, 16'h0100, 16'h0100, 16'h3FFF);
        push_elem(16'hFFFF, 1'b0);
        push_elem(16'hFFFF, 1'b0);
        // frame restart in the middle of a box
        push_elem(16'h1234, 1'b0);
        push_elem(16'h5678, 1'b0);
        push_elem(16'h9ABC, 1'b0);
        push_head(1'b1, 16'h0C00, 16'h0600, 16'h0400, 16'h0300, 16'hFFFF);
        push_elem(16'h1000, 1'b0);
        push_elem(16'hF000, 1'b0);
        settle();

        // class count raised, then lowered while a box is half gathered
        write_reg(REG_NUM_CLASSES, 16'd10);
        push_head(1'b0, 16'h0900, 16'h0700, 16'h0200, 16'h0280, 16'hE000);
        push_elem(16'h2000, 1'b0);
        push_elem(16'hC000, 1'b0);
        push_elem(16'h4000, 1'b0);
        settle();
        write_reg(REG_NUM_CLASSES, 16'd1);
        cur_classes = 1;
        push_elem(16'hFFFF, 1'b0);
        push_head(1'b0, 16'h0500, 16'h0500, 16'h0200, 16'h0200, 16'hFFFF);
        push_elem(16'hA000, 1'b0);

        // random traffic under several settings
        run_phase(16'h3000, 3, 16'h1000, 16'h1000, 640, 480, 120);
        run_phase(16'h0000, 1, 16'hFFFF, 16'h0000, 1, 8191, 120);
        run_phase(16'hFFFF, 0, 16'h0000, 16'hFFFF, 4096, 0, 80);
        run_phase(16'h2000, 255, 16'h0C00, 16'h1400, 800, 600, 150);
        run_phase($urandom_range(0, 16'h6000), 128, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(1, 4096),
                  $urandom_range(1, 4096), 80);
        run_phase(16'h1800, 7, 16'h0800, 16'h3000, 1920, 1080, 100);
        run_phase($urandom_range(0, 16'h4000), $urandom_range(1, 5), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 8191),
                  $urandom_range(0, 8191), 80);

        // output held off while every box is kept: the block fills and stalls
        settle();
        write_all(16'h0000, 1, 16'h1000, 16'h1000, 4096, 4096);
        @(posedge clk);
        hold_req = 1'b1;
        steady_feed = 1'b1;
        repeat (40) random_box(1'b0);
        settle();
        steady_feed = 1'b0;

        // drain and let the pipeline run out
        while (boxes_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && boxes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
